// File: src/peak_triggered_window_capture_unit_macros.svh
// ---------------------------------------------------------------------------
// peak triggered window capture assertion macros
// shared concurrent assertion forms for the capture unit modules
// ---------------------------------------------------------------------------
`ifndef PEAK_TRIGGERED_WINDOW_CAPTURE_UNIT_MACROS_SVH
`define PEAK_TRIGGERED_WINDOW_CAPTURE_UNIT_MACROS_SVH

// checked on every edge outside reset
`define PTWC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define PTWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ptwc_pkg.sv
// ---------------------------------------------------------------------------
// ptwc_pkg
// types and fixed codes shared by the peak triggered window capture unit
// ---------------------------------------------------------------------------
package ptwc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int OFFSET_W  = 7;
  localparam int PHASE_W   = 2;
  localparam int SLOT_W    = 2;
  localparam int OUT_DEPTH = 3;
  localparam int OCNT_W    = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [OFFSET_W-1:0]        offset_t;
  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic WIN_HIGH = 1'b0;
  localparam logic WIN_LOW  = 1'b1;

  localparam phase_t PHASE_IDLE = 2'd0;
  localparam phase_t PHASE_HIGH = 2'd1;
  localparam phase_t PHASE_LOW  = 2'd2;

  localparam slot_t SLOT_REC_RST  = 2'd0;
  localparam slot_t SLOT_HIGH_RST = 2'd1;
  localparam slot_t SLOT_LOW_RST  = 2'd2;

  // result fields of one item, the registered read data joins them in the same cycle
  typedef struct packed {
    logic    valid;
    logic    is_read;
    sample_t peak_high;
    sample_t peak_low;
    phase_t  phase;
  } s1_beat_t;

  typedef struct packed {
    sample_t read_value;
    sample_t peak_high;
    sample_t peak_low;
    phase_t  phase;
  } out_beat_t;

endpackage

// File: src/ptwc_window_mem.sv
// ---------------------------------------------------------------------------
// ptwc_window_mem
// single port sample store for the three ring buffers, with a zero sweep
// after reset and registered read data
// ---------------------------------------------------------------------------
module ptwc_window_mem import ptwc_pkg::*; #(
  parameter int DEPTH  = 384,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  sample_t           wdata,
  output sample_t           rdata,
  output logic              busy
);

  sample_t             mem [DEPTH];
  sample_t             rdata_r;
  logic                clr_busy_r;
  logic [ADDR_W-1:0]   clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

// File: src/ptwc_ctrl.sv
// ---------------------------------------------------------------------------
// ptwc_ctrl
// peak tracking, post-trigger countdowns, buffer role swaps and store
// address generation for sample and read beats
// ---------------------------------------------------------------------------
`include "peak_triggered_window_capture_unit_macros.svh"

module ptwc_ctrl import ptwc_pkg::*; #(
  parameter int WINDOW_LEN = 128,
  parameter int ADDR_W     = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_func,
  input  sample_t           in_sample_value,
  input  logic              in_read_window,
  input  offset_t           in_read_offset,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_addr,
  output sample_t           mem_wdata,
  output s1_beat_t          s1
);

  localparam int AW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int HALF = WINDOW_LEN / 2;
  localparam int CW   = $clog2(HALF + 1);

  localparam logic [AW-1:0]     POS_LAST  = AW'(WINDOW_LEN - 1);
  localparam logic [AW-1:0]     START_RST = AW'(WINDOW_LEN - HALF);
  localparam logic [AW:0]       LEN_EXT   = (AW+1)'(WINDOW_LEN);
  localparam logic [AW:0]       BACK_EXT  = (AW+1)'(WINDOW_LEN - HALF);
  localparam logic [CW-1:0]     CNT_HALF  = CW'(HALF);
  localparam logic [CW-1:0]     CNT_ONE   = CW'(1);
  localparam logic [ADDR_W-1:0] BASE1     = ADDR_W'(WINDOW_LEN);
  localparam logic [ADDR_W-1:0] BASE2     = ADDR_W'(2 * WINDOW_LEN);

  slot_t         rec_r, rec_nxt;
  slot_t         hslot_r, hslot_nxt;
  slot_t         lslot_r, lslot_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  sample_t       hval_r, hval_nxt;
  sample_t       lval_r, lval_nxt;
  logic [CW-1:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt;
  logic [AW-1:0] hstart_r, hstart_nxt;
  logic [AW-1:0] lstart_r, lstart_nxt;
  s1_beat_t      s1_r, s1_nxt;

  logic          is_push;
  logic          hi_trig, lo_trig;
  logic [AW-1:0] wp_adv;
  logic [AW:0]   start_sum;
  logic [AW-1:0] start_new;
  logic [CW-1:0] hcnt_a, lcnt_a;
  logic [AW-1:0] off_mod;
  logic [AW-1:0] rd_start;
  logic [AW:0]   idx_sum;
  logic [AW-1:0] rd_idx;
  slot_t         rd_slot;
  slot_t         base_slot;
  logic [ADDR_W-1:0] base_addr;
  logic [AW-1:0]     row_pos;
  phase_t        phase_nxt;

  assign is_push = (in_func == FUNC_PUSH);
  assign wp_adv  = (wp_r == POS_LAST) ? '0 : wp_r + AW'(1);

  // window start relative to the new center, wrapped
  assign start_sum = {1'b0, wp_adv} + BACK_EXT;
  assign start_new = (start_sum >= LEN_EXT) ? AW'(start_sum - LEN_EXT) : AW'(start_sum);

  assign hi_trig = (in_sample_value > hval_r) && (lcnt_r == '0);
  assign lo_trig = !hi_trig && (in_sample_value < lval_r) && (hcnt_r == '0);
  assign hcnt_a  = hi_trig ? CNT_HALF : hcnt_r;
  assign lcnt_a  = lo_trig ? CNT_HALF : lcnt_r;

  // offset folded into the window
  always_comb begin
    off_mod = '0;
    for (int i = 0; i < 2**OFFSET_W; i++) begin
      if (in_read_offset == OFFSET_W'(i)) begin
        off_mod = AW'(i % WINDOW_LEN);
      end
    end
  end

  assign rd_start = (in_read_window == WIN_LOW) ? lstart_r : hstart_r;
  assign rd_slot  = (in_read_window == WIN_LOW) ? lslot_r : hslot_r;
  assign idx_sum  = {1'b0, rd_start} + {1'b0, off_mod};
  assign rd_idx   = (idx_sum >= LEN_EXT) ? AW'(idx_sum - LEN_EXT) : AW'(idx_sum);

  assign base_slot = is_push ? rec_r : rd_slot;
  assign row_pos   = is_push ? wp_r : rd_idx;

  always_comb begin
    case (base_slot)
      2'd1:    base_addr = BASE1;
      2'd2:    base_addr = BASE2;
      default: base_addr = '0;
    endcase
  end

  assign mem_addr  = base_addr + ADDR_W'(row_pos);
  assign mem_we    = in_fire && is_push;
  assign mem_wdata = in_sample_value;

  always_comb begin
    rec_nxt    = rec_r;
    hslot_nxt  = hslot_r;
    lslot_nxt  = lslot_r;
    wp_nxt     = wp_r;
    hval_nxt   = hval_r;
    lval_nxt   = lval_r;
    hcnt_nxt   = hcnt_r;
    lcnt_nxt   = lcnt_r;
    hstart_nxt = hstart_r;
    lstart_nxt = lstart_r;
    if (in_fire && is_push) begin
      wp_nxt   = wp_adv;
      hcnt_nxt = hcnt_a;
      lcnt_nxt = lcnt_a;
      if (hi_trig) begin
        hval_nxt   = in_sample_value;
        hstart_nxt = start_new;
      end
      if (lo_trig) begin
        lval_nxt   = in_sample_value;
        lstart_nxt = start_new;
      end
      if (hcnt_a != '0) begin
        hcnt_nxt = hcnt_a - CNT_ONE;
        if (hcnt_a == CNT_ONE) begin
          rec_nxt   = hslot_r;
          hslot_nxt = rec_r;
        end
      end else if (lcnt_a != '0) begin
        lcnt_nxt = lcnt_a - CNT_ONE;
        if (lcnt_a == CNT_ONE) begin
          rec_nxt   = lslot_r;
          lslot_nxt = rec_r;
        end
      end
    end
  end

  always_comb begin
    if (hcnt_nxt != '0) begin
      phase_nxt = PHASE_HIGH;
    end else if (lcnt_nxt != '0) begin
      phase_nxt = PHASE_LOW;
    end else begin
      phase_nxt = PHASE_IDLE;
    end
  end

  always_comb begin
    s1_nxt           = s1_r;
    s1_nxt.valid     = in_fire;
    s1_nxt.is_read   = (in_func == FUNC_READ);
    s1_nxt.peak_high = hval_nxt;
    s1_nxt.peak_low  = lval_nxt;
    s1_nxt.phase     = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r    <= SLOT_REC_RST;
      hslot_r  <= SLOT_HIGH_RST;
      lslot_r  <= SLOT_LOW_RST;
      wp_r     <= '0;
      hval_r   <= '0;
      lval_r   <= '0;
      hcnt_r   <= '0;
      lcnt_r   <= '0;
      hstart_r <= START_RST;
      lstart_r <= START_RST;
      s1_r     <= '0;
    end else begin
      rec_r    <= rec_nxt;
      hslot_r  <= hslot_nxt;
      lslot_r  <= lslot_nxt;
      wp_r     <= wp_nxt;
      hval_r   <= hval_nxt;
      lval_r   <= lval_nxt;
      hcnt_r   <= hcnt_nxt;
      lcnt_r   <= lcnt_nxt;
      hstart_r <= hstart_nxt;
      lstart_r <= lstart_nxt;
      s1_r     <= s1_nxt;
    end
  end

  assign s1 = s1_r;

  `PTWC_ASSERT(a_slots_distinct, clk, rst_n, (rec_r != hslot_r) && (rec_r != lslot_r) && (hslot_r != lslot_r), "buffer roles overlap")
  `PTWC_ASSERT(a_one_countdown, clk, rst_n, !((hcnt_r != '0) && (lcnt_r != '0)), "both countdowns running")
  `PTWC_ASSERT(a_peak_signs, clk, rst_n, !hval_r[SAMPLE_W-1] && ((lval_r == '0) || lval_r[SAMPLE_W-1]), "peak left its sign range")

endmodule

// File: src/ptwc_out_fifo.sv
// ---------------------------------------------------------------------------
// ptwc_out_fifo
// three entry result queue that decouples the result channel from the
// store pipeline
// ---------------------------------------------------------------------------
`include "peak_triggered_window_capture_unit_macros.svh"

module ptwc_out_fifo import ptwc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_beat_t push_beat,
  input  logic      inflight,
  output logic      can_accept,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  localparam logic [OCNT_W-1:0] PTR_LAST = OCNT_W'(OUT_DEPTH - 1);
  localparam logic [OCNT_W-1:0] CNT_FULL = OCNT_W'(OUT_DEPTH);

  out_beat_t         buf_r [OUT_DEPTH];
  logic [OCNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OCNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid  = (cnt_r != '0);
  assign pop        = out_valid && out_ready;
  assign out_beat   = buf_r[rd_ptr_r];
  assign can_accept = ({1'b0, cnt_r} + (OCNT_W+1)'(inflight)) < (OCNT_W+1)'(OUT_DEPTH);

  assign wr_ptr_nxt = push ? ((wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + OCNT_W'(1)) : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ((rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + OCNT_W'(1)) : rd_ptr_r;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + OCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - OCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_beat;
    end
  end

  `PTWC_ASSERT(a_no_overflow, clk, rst_n, (push && !pop) |-> (cnt_r != CNT_FULL), "result queue overflow")
  `PTWC_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_FULL, "result queue count out of range")
  `PTWC_ASSERT(a_push_shows, clk, rst_n, (push && (cnt_r == '0)) |=> out_valid, "pushed beat not presented")

endmodule

// File: src/peak_triggered_window_capture_unit.sv
// a result is registered in the s1 stage and then in the result queue before it is offered
// throughput: one beat per cycle while in_ready is high, sample and read beats mixed freely
// rate is set by the single port sample store, one access per beat
// reset: synchronous, rst_n low; then a zero sweep of all 3*WINDOW_LEN entries
// of the sample store holds in_ready low
// ---------------------------------------------------------------------------
// peak_triggered_window_capture_unit
// captures a signed current waveform around record peaks in three rotating
// ring buffers and reads back entries of the held windows
// ---------------------------------------------------------------------------
module peak_triggered_window_capture_unit import ptwc_pkg::*; #(
  parameter int WINDOW_LEN = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_read_window,
  input  logic [OFFSET_W-1:0]        in_read_offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_read_value,
  output logic signed [SAMPLE_W-1:0] out_peak_high,
  output logic signed [SAMPLE_W-1:0] out_peak_low,
  output logic [PHASE_W-1:0]         out_capture_phase
);

  localparam int MEM_DEPTH = 3 * WINDOW_LEN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic              in_fire;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  sample_t           mem_wdata;
  sample_t           mem_rdata;
  logic              mem_busy;
  s1_beat_t          s1;
  out_beat_t         push_beat;
  out_beat_t         out_beat;
  logic              fifo_can_accept;

  assign in_ready = !mem_busy && fifo_can_accept;
  assign in_fire  = in_valid && in_ready;

  ptwc_ctrl #(
    .WINDOW_LEN (WINDOW_LEN),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_func         (in_func),
    .in_sample_value (in_sample_value),
    .in_read_window  (in_read_window),
    .in_read_offset  (in_read_offset),
    .mem_we          (mem_we),
    .mem_addr        (mem_addr),
    .mem_wdata       (mem_wdata),
    .s1              (s1)
  );

  ptwc_window_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  always_comb begin
    push_beat.read_value = s1.is_read ? mem_rdata : '0;
    push_beat.peak_high  = s1.peak_high;
    push_beat.peak_low   = s1.peak_low;
    push_beat.phase      = s1.phase;
  end

  ptwc_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1.valid),
    .push_beat  (push_beat),
    .inflight   (s1.valid),
    .can_accept (fifo_can_accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

  assign out_read_value    = out_beat.read_value;
  assign out_peak_high     = out_beat.peak_high;
  assign out_peak_low      = out_beat.peak_low;
  assign out_capture_phase = out_beat.phase;

endmodule
